[sv/utt_pkg.sv]
`default_nettype none
package utt_pkg;

  // Masks and patterns used to classify a UTF-16 code unit.
  localparam logic [15:0] ASCII_MASK   = 16'hFF80;
  localparam logic [15:0] TWO_MASK     = 16'hF800;
  localparam logic [15:0] SURR_MASK    = 16'hFC00;
  localparam logic [15:0] HIGH_SURR    = 16'hD800;
  localparam logic [15:0] LOW_SURR     = 16'hDC00;

  // UTF-8 lead and continuation byte markers.
  localparam logic [7:0] LEAD2        = 8'hC0;
  localparam logic [7:0] LEAD3        = 8'hE0;
  localparam logic [7:0] LEAD4        = 8'hF0;
  localparam logic [7:0] CONT         = 8'h80;

  localparam int unsigned MAX_BYTES   = 6;
  localparam int unsigned CNT_W       = 3;

  // One classified word: the bytes it produces, first byte in slot 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
  } job_t;

endpackage
`default_nettype wire

[sv/utt_front.sv]
`default_nettype none
module utt_front
  import utt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] code_unit,
  input  wire logic        q_full,
  output logic             push,
  output job_t             push_job
);

  logic [15:0] held_high;
  logic        held_valid;
  logic [15:0] held_high_next;
  logic        held_valid_next;
  logic        accept;

  logic [7:0]  nb0, nb1, nb2;
  logic [1:0]  ncnt;
  logic        is_low, is_high;
  logic [20:0] cp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_low   = (code_unit & SURR_MASK) == LOW_SURR;
  assign is_high  = (code_unit & SURR_MASK) == HIGH_SURR;

  // Supplementary code point from the held high and the incoming low surrogate.
  assign cp = 21'h10000 + {1'b0, held_high[9:0], code_unit[9:0]};

  // Bytes for the incoming word taken on its own.
  always_comb begin
    nb0  = 8'h00;
    nb1  = 8'h00;
    nb2  = 8'h00;
    ncnt = 2'd0;
    if (code_unit == 16'h0000) begin
      ncnt = 2'd1;
    end else if ((code_unit & ASCII_MASK) == 16'h0000) begin
      nb0  = code_unit[7:0];
      ncnt = 2'd1;
    end else if ((code_unit & TWO_MASK) == 16'h0000) begin
      nb0  = LEAD2 | {3'b000, code_unit[10:6]};
      nb1  = CONT | {2'b00, code_unit[5:0]};
      ncnt = 2'd2;
    end else if (is_high) begin
      ncnt = 2'd0;
    end else begin
      nb0  = LEAD3 | {4'h0, code_unit[15:12]};
      nb1  = CONT | {2'b00, code_unit[11:6]};
      nb2  = CONT | {2'b00, code_unit[5:0]};
      ncnt = 2'd3;
    end
  end

  // Assemble the full byte list, including a flushed or paired surrogate.
  always_comb begin
    push_job        = '0;
    held_high_next  = held_high;
    held_valid_next = held_valid;
    if (held_valid && is_low) begin
      push_job.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
      push_job.bytes[1] = CONT | {2'b00, cp[17:12]};
      push_job.bytes[2] = CONT | {2'b00, cp[11:6]};
      push_job.bytes[3] = CONT | {2'b00, cp[5:0]};
      push_job.count    = 3'd4;
    end else if (held_valid) begin
      push_job.bytes[0] = LEAD3 | {4'h0, held_high[15:12]};
      push_job.bytes[1] = CONT | {2'b00, held_high[11:6]};
      push_job.bytes[2] = CONT | {2'b00, held_high[5:0]};
      push_job.bytes[3] = nb0;
      push_job.bytes[4] = nb1;
      push_job.bytes[5] = nb2;
      push_job.count    = 3'd3 + {1'b0, ncnt};
    end else begin
      push_job.bytes[0] = nb0;
      push_job.bytes[1] = nb1;
      push_job.bytes[2] = nb2;
      push_job.count    = {1'b0, ncnt};
    end
    if (accept) begin
      if (is_high && !(held_valid && is_low)) begin
        held_high_next  = code_unit;
        held_valid_next = 1'b1;
      end else begin
        held_high_next  = 16'h0000;
        held_valid_next = 1'b0;
      end
    end
  end

  // Words that produce no bytes (a lone high surrogate) are not queued.
  assign push = accept && (push_job.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_high  <= 16'h0000;
      held_valid <= 1'b0;
    end else begin
      held_high  <= held_high_next;
      held_valid <= held_valid_next;
    end
  end

endmodule
`default_nettype wire

[sv/utt_queue.sv]
`default_nettype none
module utt_queue
  import utt_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  job_t            store [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full  = fill == DepthCnt;
  assign empty = fill == '0;
  assign head  = store[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue popped while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= DepthCnt)
    else $error("queue fill level out of range");
  a_no_empty_job: assert property (@(posedge clk) disable iff (rst)
      push |-> push_job.count != 3'd0)
    else $error("queued word carries no bytes");

endmodule
`default_nettype wire

[sv/utt_back.sv]
`default_nettype none
module utt_back
  import utt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       empty,
  input  wire job_t       head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last
);

  logic [CNT_W-1:0] idx;
  logic             load;
  logic             last;

  // The output register takes a new byte when it is empty or being drained.
  assign load = !out_valid || out_ready;
  assign last = idx == (head.count - 1'b1);
  assign pop  = load && !empty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        idx <= last ? '0 : idx + 1'b1;
      end
    end
  end

  // Byte payload needs no reset.
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_byte <= head.bytes[idx];
      run_last <= last;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
      !empty |-> idx < head.count)
    else $error("byte index past end of word");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
      empty |-> idx == '0)
    else $error("byte index not cleared at word boundary");
  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
      pop |=> out_valid && run_last)
    else $error("word retired without its last byte");

endmodule
`default_nettype wire

[sv/utf16_to_utf8_transcoder_core.sv]
// Path: with the queue empty and the output register free, an accepted word is
// written into the word queue and its first byte then into the output register.
// Throughput: one output byte per cycle while out_ready is high; a word yields
// 1 to 6 bytes (a held high surrogate alone yields none) on the single byte port.
// The front accepts a word each cycle while the word queue has room.
// Reset (rst, synchronous): clears the held surrogate, the queue and the output valid flag.
`default_nettype none
module utf16_to_utf8_transcoder_core
  import utt_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] code_unit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             run_last
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head;

  // Classification and surrogate pairing.
  utt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .code_unit(code_unit),
    .q_full   (full),
    .push     (push),
    .push_job (push_job)
  );

  // Word queue between the two halves.
  utt_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  // Byte serializer.
  utt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .run_last (run_last)
  );

endmodule
`default_nettype wire
